// ===== rtl/lirp_pkg.sv =====
// lirp_pkg: shared types and codes for the length/id record parser.
// No dependencies; used by every file under rtl/.
package lirp_pkg;

	// result kinds
	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// packet status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
	localparam logic [1:0] ST_BAD_ID    = 2'd2;
	localparam logic [1:0] ST_TRUNCATED = 2'd3;

	// input commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	// record header length in bytes
	localparam int HDR_BYTES = 8;

	// result queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = 2;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [7:0]  record_index;
		logic [15:0] data_offset;
		logic [15:0] data_length;
		logic [12:0] records_found;
		logic        last;
	} lirp_result_t;

endpackage

// ===== rtl/lirp_parse.sv =====
// lirp_parse: parser state and the combinational step logic for one transaction.
// Depends on lirp_pkg. Produces up to two results per step.
module lirp_parse #(
	parameter int LEN_BITS = 16,
	parameter int ID_BASE  = 0,
	parameter int ID_END   = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  logic                  cmd,
	input  logic [15:0]           packet_length,
	input  logic [7:0]            data_byte,
	output logic [1:0]            res_cnt,
	output lirp_pkg::lirp_result_t res0,
	output lirp_pkg::lirp_result_t res1
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	localparam logic [LEN_BITS-1:0] HDR_LEN = LEN_BITS'(lirp_pkg::HDR_BYTES);
	localparam logic [31:0]         HDR_W   = 32'(lirp_pkg::HDR_BYTES);
	localparam logic [31:0]         BASE_W  = 32'(ID_BASE);

	logic [1:0]          phase_q, ph_n;
	logic [2:0]          hdr_cnt_q, hdr_n;
	logic [31:0]         size_q, size_n;
	logic [31:0]         id_q, id_n;
	logic [LEN_BITS-1:0] remaining_q, rem_n;
	logic [LEN_BITS-1:0] position_q, pos_n;
	logic [LEN_BITS-1:0] skip_q, skip_n;
	logic [12:0]         rec_cnt_q, rec_n;
	logic [31:0]         dlen;
	logic [31:0]         idx_full;

	always_comb begin
		ph_n     = phase_q;
		hdr_n    = hdr_cnt_q;
		size_n   = size_q;
		id_n     = id_q;
		rem_n    = remaining_q;
		pos_n    = position_q;
		skip_n   = skip_q;
		rec_n    = rec_cnt_q;
		res_cnt  = 2'd0;
		res0     = '0;
		res1     = '0;
		dlen     = size_q - HDR_W;
		idx_full = '0;
		if (cmd == lirp_pkg::CMD_START) begin
			rem_n  = LEN_BITS'(packet_length);
			pos_n  = '0;
			hdr_n  = '0;
			size_n = '0;
			id_n   = '0;
			skip_n = '0;
			rec_n  = '0;
			ph_n   = PH_HEADER;
			if (rem_n < HDR_LEN) begin
				ph_n               = PH_DONE;
				res_cnt            = 2'd1;
				res0.kind          = lirp_pkg::KIND_STATUS;
				res0.status        = lirp_pkg::ST_TRUNCATED;
				res0.last          = 1'b1;
			end
		end else if (phase_q == PH_SKIP) begin
			pos_n  = position_q + 1'b1;
			skip_n = skip_q - 1'b1;
			if (skip_n == '0) begin
				hdr_n = '0;
				ph_n  = PH_HEADER;
			end
		end else if (phase_q == PH_HEADER) begin
			pos_n = position_q + 1'b1;
			if (!hdr_cnt_q[2]) begin
				// size bytes, little endian
				size_n = {data_byte, size_q[31:8]};
				hdr_n  = hdr_cnt_q + 1'b1;
				if (hdr_cnt_q == 3'd3 &&
				    (size_n[31] || size_n < HDR_W || size_n > 32'(remaining_q))) begin
					ph_n               = PH_DONE;
					res_cnt            = 2'd1;
					res0.kind          = lirp_pkg::KIND_STATUS;
					res0.status        = lirp_pkg::ST_BAD_SIZE;
					res0.records_found = rec_cnt_q;
					res0.last          = 1'b1;
				end
			end else begin
				id_n  = {data_byte, id_q[31:8]};
				hdr_n = hdr_cnt_q + 1'b1;
				if (hdr_cnt_q == 3'd7) begin
					if (!($signed(id_n) > ID_BASE && $signed(id_n) < ID_END)) begin
						ph_n               = PH_DONE;
						res_cnt            = 2'd1;
						res0.kind          = lirp_pkg::KIND_STATUS;
						res0.status        = lirp_pkg::ST_BAD_ID;
						res0.records_found = rec_cnt_q;
						res0.last          = 1'b1;
					end else begin
						idx_full           = id_n - BASE_W;
						rec_n              = rec_cnt_q + 1'b1;
						rem_n              = remaining_q - LEN_BITS'(size_q);
						res_cnt            = 2'd1;
						res0.kind          = lirp_pkg::KIND_RECORD;
						res0.status        = lirp_pkg::ST_OK;
						res0.record_index  = idx_full[7:0];
						res0.data_offset   = 16'(pos_n);
						res0.data_length   = dlen[15:0];
						res0.records_found = rec_n;
						res1.kind          = lirp_pkg::KIND_STATUS;
						res1.records_found = rec_n;
						res1.last          = 1'b1;
						if (rem_n == '0) begin
							ph_n        = PH_DONE;
							res_cnt     = 2'd2;
							res1.status = lirp_pkg::ST_OK;
						end else if (rem_n < HDR_LEN) begin
							ph_n        = PH_DONE;
							res_cnt     = 2'd2;
							res1.status = lirp_pkg::ST_TRUNCATED;
						end else begin
							res0.last = 1'b1;
							if (dlen != '0) begin
								skip_n = LEN_BITS'(dlen);
								ph_n   = PH_SKIP;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hdr_cnt_q   <= '0;
			size_q      <= '0;
			id_q        <= '0;
			remaining_q <= '0;
			position_q  <= '0;
			skip_q      <= '0;
			rec_cnt_q   <= '0;
		end else if (step_en) begin
			phase_q     <= ph_n;
			hdr_cnt_q   <= hdr_n;
			size_q      <= size_n;
			id_q        <= id_n;
			remaining_q <= rem_n;
			position_q  <= pos_n;
			skip_q      <= skip_n;
			rec_cnt_q   <= rec_n;
		end
	end

`ifndef SYNTHESIS
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && res_cnt == 2'd2) |->
		(res0.kind == lirp_pkg::KIND_RECORD && !res0.last &&
		 res1.kind == lirp_pkg::KIND_STATUS && res1.last))
		else $error("two-result step not record then status");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_q != '0))
		else $error("skip phase with nothing left to skip");

	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && res_cnt == 2'd1 && res0.kind == lirp_pkg::KIND_STATUS)
		|=> (phase_q == PH_DONE))
		else $error("status reported but packet not closed");
`endif

endmodule

// ===== rtl/lirp_outq.sv =====
// lirp_outq: four-entry result queue taking up to two results per cycle.
// Depends on lirp_pkg.
module lirp_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             push_cnt,
	input  lirp_pkg::lirp_result_t push0,
	input  lirp_pkg::lirp_result_t push1,
	output logic                   room2,
	output logic                   out_valid,
	input  logic                   out_ready,
	output lirp_pkg::lirp_result_t head
);

	localparam int CW = lirp_pkg::OUTQ_AW + 1;

	lirp_pkg::lirp_result_t         mem_q [lirp_pkg::OUTQ_DEPTH];
	logic [lirp_pkg::OUTQ_AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]                  count_q;
	logic                           pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_q];
	// room for a two-result step, independent of the receiver this cycle
	assign room2     = (count_q <= CW'(lirp_pkg::OUTQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_q] <= push0;
		if (push_cnt == 2'd2)
			mem_q[wr_q + 1'b1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push_cnt;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + CW'(push_cnt) - CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> room2)
		else $error("result queue pushed without room");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push_cnt == 2'd0) |=> (count_q == $past(count_q) - 1'b1))
		else $error("result queue count not reduced on pop");
`endif

endmodule

// ===== rtl/length_id_record_parser_top.sv =====
// length_id_record_parser_top: top level of the chained record parser.
// Depends on lirp_pkg, lirp_parse and lirp_outq.
//
// Usage:
//  - Input channel (in_valid/in_ready): a transaction with cmd = start loads
//    packet_length; cmd = byte feeds one packet byte in data_byte.
//  - Output channel (out_valid/out_ready): one result per transaction, either
//    a record (id index, data offset, data length) or a final packet status.
//  - Timing: an accepted input transaction is held in the input register; the
//    step then writes its results into the result queue once the queue has
//    room for two, and the output is presented from the queue.
//  - Throughput: one input transaction per cycle while the queue has room.
//    The step logic sits between the input register and a four-entry
//    result queue; a record plus a final status takes two output transactions.
//  - A stalled receiver fills the result queue; the held transaction waits
//    and in_ready drops once fewer than two free entries remain. in_ready
//    never depends on out_ready in the same cycle.
//  - Reset (arst_n low) empties the queue and returns the parser to idle:
//    bytes are ignored until a start transaction arrives.
module length_id_record_parser_top #(
	parameter int LEN_BITS = 16,
	parameter int ID_BASE  = 0,
	parameter int ID_END   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] packet_length,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [1:0]  status,
	output logic [7:0]  record_index,
	output logic [15:0] data_offset,
	output logic [15:0] data_length,
	output logic [12:0] records_found,
	output logic        last
);

	// input register stage
	logic        vld_s1;
	logic        cmd_s1;
	logic [15:0] len_s1;
	logic [7:0]  byte_s1;

	logic                   room2;
	logic                   step_en;
	logic [1:0]             res_cnt;
	logic [1:0]             push_cnt;
	lirp_pkg::lirp_result_t res0, res1, head;

	// the held transaction steps the parser when the queue can take two results
	assign step_en  = vld_s1 && room2;
	assign in_ready = !vld_s1 || room2;
	assign push_cnt = step_en ? res_cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd;
			len_s1  <= packet_length;
			byte_s1 <= data_byte;
		end
	end

	lirp_parse #(
		.LEN_BITS (LEN_BITS),
		.ID_BASE  (ID_BASE),
		.ID_END   (ID_END)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (step_en),
		.cmd           (cmd_s1),
		.packet_length (len_s1),
		.data_byte     (byte_s1),
		.res_cnt       (res_cnt),
		.res0          (res0),
		.res1          (res1)
	);

	lirp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (res0),
		.push1     (res1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind          = head.kind;
	assign status        = head.status;
	assign record_index  = head.record_index;
	assign data_offset   = head.data_offset;
	assign data_length   = head.data_length;
	assign records_found = head.records_found;
	assign last          = head.last;

endmodule

// ===== tb/lirp_scoreboard_pkg.sv =====
// lirp_scoreboard_pkg: byte-level predictor and result checker for the record parser bench.
// Depends on lirp_pkg for the result layout, command, kind and status codes.
package lirp_scoreboard_pkg;

	typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_SKIP, PH_DONE} parse_phase_t;

	class record_scoreboard #(int ID_LO = 0, int ID_HI = 64);
		parse_phase_t phase;
		logic [2:0]   hdr_count;
		logic [31:0]  size_acc;
		logic [31:0]  id_acc;
		logic [15:0]  remaining;
		logic [15:0]  position;
		logic [15:0]  skip_left;
		logic [12:0]  rec_count;

		lirp_pkg::lirp_result_t expected[$];
		int errors;
		int inputs_in;
		int ignored_in;
		int records_out;
		int statuses_out;

		function new();
			phase        = PH_IDLE;
			hdr_count    = '0;
			size_acc     = '0;
			id_acc       = '0;
			remaining    = '0;
			position     = '0;
			skip_left    = '0;
			rec_count    = '0;
			errors       = 0;
			inputs_in    = 0;
			ignored_in   = 0;
			records_out  = 0;
			statuses_out = 0;
		endfunction

		function int useful_in();
			return inputs_in - ignored_in;
		endfunction

		function void end_packet(logic [1:0] st);
			lirp_pkg::lirp_result_t r;
			r               = '0;
			r.kind          = lirp_pkg::KIND_STATUS;
			r.status        = st;
			r.records_found = rec_count;
			r.last          = 1'b1;
			expected.push_back(r);
			phase = PH_DONE;
		endfunction

		// full header seen: check the id, then report the record
		function void take_record();
			int                     id_val;
			logic [15:0]            dlen;
			lirp_pkg::lirp_result_t r;
			id_val = id_acc;
			if (id_val <= ID_LO || id_val >= ID_HI) begin
				end_packet(lirp_pkg::ST_BAD_ID);
				return;
			end
			dlen      = size_acc[15:0] - 16'd8;
			rec_count = rec_count + 13'd1;
			remaining = remaining - size_acc[15:0];
			r               = '0;
			r.kind          = lirp_pkg::KIND_RECORD;
			r.status        = lirp_pkg::ST_OK;
			r.record_index  = 8'(id_val - ID_LO);
			r.data_offset   = position;
			r.data_length   = dlen;
			r.records_found = rec_count;
			if (remaining == 16'd0) begin
				expected.push_back(r);
				end_packet(lirp_pkg::ST_OK);
			end else if (remaining < lirp_pkg::HDR_BYTES) begin
				expected.push_back(r);
				end_packet(lirp_pkg::ST_TRUNCATED);
			end else begin
				r.last = 1'b1;
				expected.push_back(r);
				if (dlen != 16'd0) begin
					skip_left = dlen;
					phase     = PH_SKIP;
				end
			end
		endfunction

		function void note_input(logic c, logic [15:0] len, logic [7:0] b);
			int sz;
			int rem_i;
			inputs_in++;
			if (c == lirp_pkg::CMD_START) begin
				remaining = len;
				position  = '0;
				hdr_count = '0;
				size_acc  = '0;
				id_acc    = '0;
				skip_left = '0;
				rec_count = '0;
				phase     = PH_HEADER;
				if (remaining < lirp_pkg::HDR_BYTES)
					end_packet(lirp_pkg::ST_TRUNCATED);
				return;
			end
			case (phase)
				PH_SKIP: begin
					position  = position + 16'd1;
					skip_left = skip_left - 16'd1;
					if (skip_left == 16'd0) begin
						hdr_count = '0;
						phase     = PH_HEADER;
					end
				end
				PH_HEADER: begin
					position = position + 16'd1;
					if (hdr_count < 3'd4) begin
						size_acc  = {b, size_acc[31:8]};
						hdr_count = hdr_count + 3'd1;
						if (hdr_count == 3'd4) begin
							sz    = size_acc;
							rem_i = remaining;
							if (sz < lirp_pkg::HDR_BYTES || sz > rem_i)
								end_packet(lirp_pkg::ST_BAD_SIZE);
						end
					end else begin
						id_acc    = {b, id_acc[31:8]};
						hdr_count = hdr_count + 3'd1;
						if (hdr_count == 3'd0)
							take_record();
					end
				end
				default: ignored_in++;
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_field(string name, logic [15:0] got_v, logic [15:0] exp_v);
			if (got_v !== exp_v)
				report($sformatf("result %0d field %s got %0h expected %0h",
					records_out + statuses_out, name, got_v, exp_v));
		endtask

		task check_result(lirp_pkg::lirp_result_t got);
			lirp_pkg::lirp_result_t exp;
			if (expected.size() == 0) begin
				report($sformatf("result %h arrived with nothing outstanding", got));
				return;
			end
			exp = expected.pop_front();
			check_field("kind", 16'(got.kind), 16'(exp.kind));
			check_field("status", 16'(got.status), 16'(exp.status));
			check_field("record_index", 16'(got.record_index), 16'(exp.record_index));
			check_field("data_offset", got.data_offset, exp.data_offset);
			check_field("data_length", got.data_length, exp.data_length);
			check_field("records_found", 16'(got.records_found), 16'(exp.records_found));
			check_field("last", 16'(got.last), 16'(exp.last));
			if (exp.kind == lirp_pkg::KIND_RECORD)
				records_out++;
			else
				statuses_out++;
		endtask
	endclass

endpackage

// ===== tb/length_id_record_parser_top_test.sv =====
// length_id_record_parser_top_test: self-checking bench for the chained record parser.
// Depends on lirp_pkg, lirp_scoreboard_pkg and the RTL under rtl/.
module length_id_record_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_BASE         = 0;
	localparam int ID_END          = 64;
	localparam int LEN_BITS        = 16;
	localparam int CLK_PERIOD      = 12;
	localparam int ITEMS_PER_PHASE = 540;
	localparam int TAIL_CYCLES     = 8;
	localparam int LIMIT_CYCLES    = 400_000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [15:0] packet_length;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [1:0]  status;
	logic [7:0]  record_index;
	logic [15:0] data_offset;
	logic [15:0] data_length;
	logic [12:0] records_found;
	logic        last;

	lirp_pkg::lirp_result_t got_result;
	assign got_result = {kind, status, record_index, data_offset, data_length,
		records_found, last};

	// idle odds (in percent) for each side; changed between test phases
	int snd_idle;
	int rcv_idle;

	// bytes of the packet being built, sent after its start transaction
	logic [7:0] pkt[$];

	lirp_scoreboard_pkg::record_scoreboard #(ID_BASE, ID_END) sb;

	length_id_record_parser_top #(
		.LEN_BITS(LEN_BITS),
		.ID_BASE (ID_BASE),
		.ID_END  (ID_END)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.packet_length(packet_length),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.status       (status),
		.record_index (record_index),
		.data_offset  (data_offset),
		.data_length  (data_length),
		.records_found(records_found),
		.last         (last)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// Result side: values read at the edge are the pre-edge ones, so a
	// transaction is seen exactly as the block saw it. out_ready gets one
	// fresh random value per cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(got_result);
		out_ready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	// One input transaction. Random idle cycles go in front with valid low;
	// once valid is raised it stays up, payload held, until in_ready is seen.
	// Returns at the accepting edge, so the next call may drive straight on.
	task automatic send_item(input logic c, input logic [15:0] len, input logic [7:0] b);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		packet_length <= len;
		data_byte     <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(cmd, packet_length, data_byte);
	endtask

	// start transaction, then every queued byte; unused fields carry noise
	task automatic send_packet(input logic [15:0] len);
		send_item(lirp_pkg::CMD_START, len, 8'($urandom));
		foreach (pkt[i])
			send_item(lirp_pkg::CMD_BYTE, 16'($urandom), pkt[i]);
		pkt.delete();
	endtask

	function automatic void put_word(logic [31:0] w);
		for (int i = 0; i < 4; i++)
			pkt.push_back(w[8*i +: 8]);
	endfunction

	function automatic void put_data(int unsigned n);
		repeat (n)
			pkt.push_back(8'($urandom));
	endfunction

	// mostly short records, a few long ones to keep the skip counter busy
	function automatic int unsigned pick_dlen();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 0;
		if (r < 90)
			return $urandom_range(1, 12);
		if (r < 98)
			return $urandom_range(13, 80);
		return $urandom_range(81, 1500);
	endfunction

	function automatic logic [31:0] pick_good_id();
		case ($urandom_range(0, 9))
			0:       return 32'(ID_BASE + 1);
			1:       return 32'(ID_END - 1);
			default: return $urandom_range(ID_BASE + 1, ID_END - 1);
		endcase
	endfunction

	// ids on and beyond both bounds, signed and huge
	function automatic logic [31:0] pick_bad_id();
		case ($urandom_range(0, 6))
			0:       return 32'(ID_BASE);
			1:       return 32'(ID_END);
			2:       return 32'(ID_END) + $urandom_range(1, 1000);
			3:       return $urandom | 32'h8000_0000;
			4:       return 32'h7FFF_FFFF;
			5:       return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// One packet. Most are well formed; the rest end on a bad size, a bad id,
	// a short length, random bytes, or are cut off by the next start.
	task automatic random_packet();
		int unsigned roll;
		int unsigned nrec;
		int unsigned dlen;
		int unsigned body;
		int unsigned extra;
		logic [31:0] bad;
		logic [15:0] len;
		roll = $urandom_range(0, 99);
		nrec = $urandom_range(1, 4);
		if (roll >= 55)
			nrec--;
		for (int i = 0; i < nrec; i++) begin
			dlen = pick_dlen();
			put_word(dlen + 8);
			put_word(pick_good_id());
			put_data(dlen);
		end
		body = pkt.size();
		if (roll < 55) begin
			len = 16'(body);
			// a 1..7 byte tail gives truncated, and its bytes are then ignored
			if ($urandom_range(0, 4) == 0) begin
				extra = $urandom_range(1, 7);
				len   = len + 16'(extra);
				put_data(extra);
			end
			if ($urandom_range(0, 9) == 0)
				put_data($urandom_range(1, 6));
		end else if (roll < 67) begin
			extra = $urandom_range(8, 64);
			len   = 16'(body + extra);
			case ($urandom_range(0, 5))
				0:       bad = $urandom_range(0, 7);
				1:       bad = $urandom | 32'h8000_0000;
				2:       bad = extra + $urandom_range(1, 64);
				3:       bad = 32'h7FFF_FFFF;
				4:       bad = 32'h8000_0000;
				default: bad = $urandom;
			endcase
			put_word(bad);
			put_data($urandom_range(0, 4));
		end else if (roll < 79) begin
			dlen = $urandom_range(0, 6);
			put_word(dlen + 8);
			put_word(pick_bad_id());
			put_data(dlen);
			len = 16'(pkt.size() + $urandom_range(0, 16));
		end else if (roll < 85) begin
			pkt.delete();
			len = 16'($urandom_range(0, 7));
			put_data($urandom_range(0, 10));
		end else if (roll < 92) begin
			pkt.delete();
			len = 16'($urandom);
			put_data($urandom_range(0, 24));
		end else begin
			// restart: the next start lands anywhere inside this packet
			len   = 16'(body + $urandom_range(0, 16));
			extra = $urandom_range(0, body);
			while (pkt.size() > extra)
				void'(pkt.pop_back());
		end
		send_packet(len);
	endtask

	// hold the sender off until every outstanding result has been checked
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected.size() != 0);
	endtask

	initial begin
		int target;
		sb            = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = lirp_pkg::CMD_BYTE;
		packet_length = '0;
		data_byte     = '0;
		snd_idle      = 12;
		rcv_idle      = 69;
		repeat (11)
			@(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed: a byte before any start, short lengths of 0 and 7, a
		// restart of a full-length packet, a negative size, a byte after the
		// final status, the top valid id with a truncated tail, an id at the
		// upper bound
		send_item(lirp_pkg::CMD_BYTE, 16'hFFFF, 8'hFF);
		send_packet(16'd0);
		send_packet(16'd7);
		pkt.push_back(8'h00);
		pkt.push_back(8'h00);
		send_packet(16'hFFFF);
		put_word(32'hFFFF_FFFF);
		send_packet(16'd8);
		send_item(lirp_pkg::CMD_BYTE, 16'h0000, 8'h00);
		put_word(32'd8);
		put_word(32'(ID_END - 1));
		send_packet(16'd15);
		put_word(32'd8);
		put_word(32'(ID_END));
		send_packet(16'd8);
		drain();

		// random: busy sender with a slow receiver, then the reverse,
		// then both flat out; each phase ends with the sender held off
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					snd_idle = 12;
					rcv_idle = 69;
				end
				1: begin
					snd_idle = 69;
					rcv_idle = 12;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			target = sb.useful_in() + ITEMS_PER_PHASE;
			while (sb.useful_in() < target)
				random_packet();
			drain();
		end

		// anything arriving now is unexpected and gets flagged by the checker
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (sb.expected.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected.size()));
		$display("covered %0d input transactions (%0d outside a packet),",
			sb.inputs_in, sb.ignored_in);
		$display("  %0d records and %0d packet statuses checked, %0d mismatches",
			sb.records_out, sb.statuses_out, sb.errors);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("timeout after %0d cycles", LIMIT_CYCLES);
		$display("status: fail");
		$finish;
	end

endmodule
